// ----- design/ggnt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggnt_pkg: shared types and constants of the grid graph neighbour table
// Field widths, command and result records, function and register codes.
// ----------------------------------------------------------------------------
package ggnt_pkg;

	localparam int FUNC_W   = 2;
	localparam int COORD_W  = 6;
	localparam int GRID_W   = 7;   // grid_width / grid_height registers
	localparam int AREA_W   = 14;  // product of two GRID_W values
	localparam int IDX_W    = 13;  // cell index and load position
	localparam int VNUM_W   = 12;  // vertex and cell numbers on the result side
	localparam int TOTAL_W  = 13;  // vertex counter
	localparam int CFG_IDX_W = 1;

	localparam logic [FUNC_W-1:0] FUNC_BEGIN = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

	localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;

	typedef enum logic [1:0] {
		CMD_BEGIN,
		CMD_LOAD,
		CMD_QUERY
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic              blocked;
		logic              in_grid;
		logic              has_left;
		logic              has_right;
		logic              has_up;
		logic              has_down;
		logic [IDX_W-1:0]  idx;
	} cmd_t;

	typedef struct packed {
		logic [GRID_W-1:0] width;
		logic [AREA_W-1:0] area;
	} sizes_t;

	typedef struct packed {
		logic              free;
		logic [VNUM_W-1:0] vnum;
	} ram_word_t;

	typedef struct packed {
		logic               vertex_present;
		logic [VNUM_W-1:0]  vertex_number;
		logic [VNUM_W-1:0]  cell_number;
		logic               left_present;
		logic [VNUM_W-1:0]  left_number;
		logic               right_present;
		logic [VNUM_W-1:0]  right_number;
		logic               up_present;
		logic [VNUM_W-1:0]  up_number;
		logic               down_present;
		logic [VNUM_W-1:0]  down_number;
		logic [TOTAL_W-1:0] vertex_total;
	} res_t;

endpackage

// ----- design/ggnt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggnt_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ggnt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/ggnt_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggnt_fifo: small register queue
// Decouples producer and consumer; push and pop may happen in one cycle.
// ----------------------------------------------------------------------------
module ggnt_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           din,
	output logic                       full,
	input  logic                       pop,
	output logic [WIDTH-1:0]           dout,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign dout    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ----- design/ggnt_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggnt_front: configuration registers and item classifier
// Clamps the grid size, decodes func and precomputes the cell index and
// the neighbour bounds of a query before the item enters the command queue.
// ----------------------------------------------------------------------------
module ggnt_front #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic [ggnt_pkg::FUNC_W-1:0]     func,
	input  logic                            cell_blocked,
	input  logic [ggnt_pkg::COORD_W-1:0]    query_x,
	input  logic [ggnt_pkg::COORD_W-1:0]    query_y,
	input  logic                            wr_en,
	input  logic [ggnt_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [ggnt_pkg::GRID_W-1:0]     wr_data,
	input  logic                            cmd_full,
	output logic                            cmd_push,
	output ggnt_pkg::cmd_t                  cmd,
	output ggnt_pkg::sizes_t                sizes
);

	import ggnt_pkg::*;

	logic [GRID_W-1:0] grid_width_q, grid_height_q;
	logic [GRID_W-1:0] eff_w, eff_h;
	logic [GRID_W-1:0] x_ext, y_ext;
	logic              func_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_RESET;
			grid_height_q <= GRID_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_GRID_WIDTH:  grid_width_q  <= wr_data;
				REG_GRID_HEIGHT: grid_height_q <= wr_data;
			endcase
		end
	end

	always_comb begin
		// zero counts as one, anything past the maximum counts as the maximum
		if (grid_width_q == '0) begin
			eff_w = GRID_W'(1);
		end else if (int'(grid_width_q) > MAX_WIDTH) begin
			eff_w = GRID_W'(MAX_WIDTH);
		end else begin
			eff_w = grid_width_q;
		end
		if (grid_height_q == '0) begin
			eff_h = GRID_W'(1);
		end else if (int'(grid_height_q) > MAX_HEIGHT) begin
			eff_h = GRID_W'(MAX_HEIGHT);
		end else begin
			eff_h = grid_height_q;
		end
	end

	assign sizes.width = eff_w;
	assign sizes.area  = AREA_W'(eff_w) * AREA_W'(eff_h);

	assign x_ext = GRID_W'(query_x);
	assign y_ext = GRID_W'(query_y);

	always_comb begin
		cmd           = '0;
		func_ok       = 1'b1;
		cmd.blocked   = cell_blocked;
		cmd.in_grid   = (x_ext < eff_w) && (y_ext < eff_h);
		cmd.has_left  = (query_x != '0);
		cmd.has_right = ((x_ext + GRID_W'(1)) < eff_w);
		cmd.has_up    = ((y_ext + GRID_W'(1)) < eff_h);
		cmd.has_down  = (query_y != '0);
		cmd.idx       = IDX_W'(eff_w) * IDX_W'(query_y) + IDX_W'(query_x);
		unique case (func)
			FUNC_BEGIN: cmd.kind = CMD_BEGIN;
			FUNC_LOAD:  cmd.kind = CMD_LOAD;
			FUNC_QUERY: cmd.kind = CMD_QUERY;
			default: begin
				// drop the unused code: accepted, never queued
				cmd.kind = CMD_BEGIN;
				func_ok  = 1'b0;
			end
		endcase
		cmd_push = push && !cmd_full && func_ok;
	end

endmodule

// ----- design/ggnt_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggnt_back: command execution and result queue
// Loads write the cell store copies; a query reads five copies at once and
// assembles the neighbour record in the following cycle into the result queue.
// ----------------------------------------------------------------------------
module ggnt_back #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_empty,
	input  ggnt_pkg::cmd_t   cmd,
	input  ggnt_pkg::sizes_t sizes,
	output logic             cmd_pop,
	input  logic             pop,
	output logic             empty,
	output ggnt_pkg::res_t   res
);

	import ggnt_pkg::*;

	localparam int CELLS     = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int RES_DEPTH = 2;
	localparam int CNT_W     = $clog2(RES_DEPTH + 1);
	localparam int SUM_W     = CNT_W + 1;
	localparam int RAM_W     = $bits(ram_word_t);
	localparam int NUM_PRB   = 5;
	localparam int PRB_C     = 0;
	localparam int PRB_L     = 1;
	localparam int PRB_R     = 2;
	localparam int PRB_U     = 3;
	localparam int PRB_D     = 4;

	logic [IDX_W-1:0]   load_pos_q;
	logic [TOTAL_W-1:0] vcount_q;

	logic [IDX_W-1:0]   prb_addr [NUM_PRB];
	logic [NUM_PRB-1:0] prb_en, prb_live;
	logic [RAM_W-1:0]   rd_raw   [NUM_PRB];
	ram_word_t          rd       [NUM_PRB];

	logic               q_valid_s1;
	logic [NUM_PRB-1:0] live_s1;
	logic               in_grid_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [TOTAL_W-1:0] vtotal_s1;

	logic [CNT_W-1:0]   res_count;
	logic               res_full;
	logic               room, is_query, load_in, ram_we;
	ram_word_t          wr_word;
	res_t               res_next;

	always_comb begin
		prb_addr[PRB_C] = cmd.idx;
		prb_addr[PRB_L] = cmd.idx - IDX_W'(1);
		prb_addr[PRB_R] = cmd.idx + IDX_W'(1);
		prb_addr[PRB_U] = cmd.idx + IDX_W'(sizes.width);
		prb_addr[PRB_D] = cmd.idx - IDX_W'(sizes.width);
		prb_en[PRB_C]   = cmd.in_grid;
		prb_en[PRB_L]   = cmd.in_grid && cmd.has_left;
		prb_en[PRB_R]   = cmd.in_grid && cmd.has_right;
		prb_en[PRB_U]   = cmd.in_grid && cmd.has_up;
		prb_en[PRB_D]   = cmd.in_grid && cmd.has_down;
		// a cell counts only once loaded since the last begin
		for (int i = 0; i < NUM_PRB; i++) begin
			prb_live[i] = prb_en[i] && (prb_addr[i] < load_pos_q);
		end
	end

	assign is_query = (cmd.kind == CMD_QUERY);
	// reserve a result slot for the query in flight
	assign room     = (SUM_W'(res_count) + SUM_W'(q_valid_s1)) < SUM_W'(RES_DEPTH);
	assign cmd_pop  = !cmd_empty && (!is_query || room);
	assign load_in  = AREA_W'(load_pos_q) < sizes.area;
	assign ram_we   = cmd_pop && (cmd.kind == CMD_LOAD) && load_in;

	assign wr_word.free = !cmd.blocked;
	assign wr_word.vnum = VNUM_W'(vcount_q);

	for (genvar g = 0; g < NUM_PRB; g++) begin : g_copy
		ggnt_ram #(
			.WIDTH (RAM_W),
			.DEPTH (CELLS)
		) u_ram (
			.clk   (clk),
			.we    (ram_we),
			.waddr (ADDR_W'(load_pos_q)),
			.wdata (wr_word),
			.raddr (ADDR_W'(prb_addr[g])),
			.rdata (rd_raw[g])
		);
		assign rd[g] = ram_word_t'(rd_raw[g]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
			vcount_q   <= '0;
			q_valid_s1 <= 1'b0;
		end else begin
			q_valid_s1 <= cmd_pop && is_query;
			if (cmd_pop) begin
				unique case (cmd.kind)
					CMD_BEGIN: begin
						load_pos_q <= '0;
						vcount_q   <= '0;
					end
					CMD_LOAD: begin
						if (load_in) begin
							load_pos_q <= load_pos_q + IDX_W'(1);
							if (!cmd.blocked) begin
								vcount_q <= vcount_q + TOTAL_W'(1);
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// snapshot the query context alongside the registered reads
	always_ff @(posedge clk) begin
		if (cmd_pop && is_query) begin
			live_s1    <= prb_live;
			in_grid_s1 <= cmd.in_grid;
			idx_s1     <= cmd.idx;
			vtotal_s1  <= vcount_q;
		end
	end

	always_comb begin
		res_next              = '0;
		res_next.vertex_total = vtotal_s1;
		if (in_grid_s1) begin
			res_next.cell_number = VNUM_W'(idx_s1);
		end
		if (live_s1[PRB_C] && rd[PRB_C].free) begin
			res_next.vertex_present = 1'b1;
			res_next.vertex_number  = rd[PRB_C].vnum;
			res_next.left_present   = live_s1[PRB_L] && rd[PRB_L].free;
			res_next.right_present  = live_s1[PRB_R] && rd[PRB_R].free;
			res_next.up_present     = live_s1[PRB_U] && rd[PRB_U].free;
			res_next.down_present   = live_s1[PRB_D] && rd[PRB_D].free;
			res_next.left_number    = res_next.left_present  ? rd[PRB_L].vnum : '0;
			res_next.right_number   = res_next.right_present ? rd[PRB_R].vnum : '0;
			res_next.up_number      = res_next.up_present    ? rd[PRB_U].vnum : '0;
			res_next.down_number    = res_next.down_present  ? rd[PRB_D].vnum : '0;
		end
	end

	ggnt_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_valid_s1),
		.din    (res_next),
		.full   (res_full),
		.pop    (pop),
		.dout   (res),
		.empty  (empty),
		.count  (res_count)
	);

	// slot reservation keeps the queue from overflowing
	always_comb begin
		if (q_valid_s1 && res_full) begin
			$error("result queue overflow");
		end
	end

endmodule

// ----- design/grid_to_graph_neighbour_table_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_to_graph_neighbour_table_core: four-connected grid graph builder
// Loads an occupancy grid cell by cell, numbers free cells densely and
// answers neighbour queries.
//
//   channel  | signals                                   | transfer when
//   ---------+-------------------------------------------+-----------------
//   command  | push, full, func, cell_blocked, query_x/y | push && !full
//   result   | pop, empty, vertex_* .. vertex_total      | pop && !empty
//   config   | wr_en, wr_index, wr_data                  | wr_en
//
// One item per cycle enters while the command queue has room; a load is one
// write to all five copies of the cell store, a query one read of each.
// A query passes the command queue, the registered store reads and the result queue.
// Reset needs no clearing pass: the load position marks which cells count.
// The sides stall independently; a query waits in the command queue while the
// result queue and the query in its read stage take both result slots.
// ----------------------------------------------------------------------------
module grid_to_graph_neighbour_table_core #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [ggnt_pkg::FUNC_W-1:0]     func,
	input  logic                            cell_blocked,
	input  logic [ggnt_pkg::COORD_W-1:0]    query_x,
	input  logic [ggnt_pkg::COORD_W-1:0]    query_y,
	input  logic                            pop,
	output logic                            empty,
	output logic                            vertex_present,
	output logic [ggnt_pkg::VNUM_W-1:0]     vertex_number,
	output logic [ggnt_pkg::VNUM_W-1:0]     cell_number,
	output logic                            left_present,
	output logic [ggnt_pkg::VNUM_W-1:0]     left_number,
	output logic                            right_present,
	output logic [ggnt_pkg::VNUM_W-1:0]     right_number,
	output logic                            up_present,
	output logic [ggnt_pkg::VNUM_W-1:0]     up_number,
	output logic                            down_present,
	output logic [ggnt_pkg::VNUM_W-1:0]     down_number,
	output logic [ggnt_pkg::TOTAL_W-1:0]    vertex_total,
	input  logic                            wr_en,
	input  logic [ggnt_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [ggnt_pkg::GRID_W-1:0]     wr_data
);

	import ggnt_pkg::*;

	localparam int CMD_DEPTH = 2;

	cmd_t   cmd_in, cmd_head;
	sizes_t sizes;
	logic   cmd_push, cmd_pop, cmd_full, cmd_empty;
	res_t   res;

	ggnt_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.func         (func),
		.cell_blocked (cell_blocked),
		.query_x      (query_x),
		.query_y      (query_y),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.cmd_full     (cmd_full),
		.cmd_push     (cmd_push),
		.cmd          (cmd_in),
		.sizes        (sizes)
	);

	ggnt_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.dout   (cmd_head),
		.empty  (cmd_empty),
		.count  ()
	);

	ggnt_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_head),
		.sizes     (sizes),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.res       (res)
	);

	assign full           = cmd_full;
	assign vertex_present = res.vertex_present;
	assign vertex_number  = res.vertex_number;
	assign cell_number    = res.cell_number;
	assign left_present   = res.left_present;
	assign left_number    = res.left_number;
	assign right_present  = res.right_present;
	assign right_number   = res.right_number;
	assign up_present     = res.up_present;
	assign up_number      = res.up_number;
	assign down_present   = res.down_present;
	assign down_number    = res.down_number;
	assign vertex_total   = res.vertex_total;

endmodule

// ----- design/ggnt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggnt_checker: port-level checks of the grid graph neighbour table
// Watches the result side of the top level; attached by bind.
// ----------------------------------------------------------------------------
module ggnt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pop,
	input logic                          empty,
	input logic                          vertex_present,
	input logic [ggnt_pkg::VNUM_W-1:0]   vertex_number,
	input logic                          left_present,
	input logic [ggnt_pkg::VNUM_W-1:0]   left_number,
	input logic                          right_present,
	input logic [ggnt_pkg::VNUM_W-1:0]   right_number,
	input logic                          up_present,
	input logic                          down_present,
	input logic [ggnt_pkg::TOTAL_W-1:0]  vertex_total
);

	import ggnt_pkg::*;

	// nothing waits while reset is held
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result waiting during reset");

	// a non-vertex has no neighbours and no number
	a_no_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !vertex_present |->
			!left_present && !right_present && !up_present && !down_present &&
			vertex_number == '0)
		else $error("neighbours reported for a non-vertex");

	// numbers are handed out densely below the running total
	a_number_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && vertex_present |-> TOTAL_W'(vertex_number) < vertex_total)
		else $error("vertex number not below vertex total");

	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (left_present || left_number == '0) &&
			(right_present || right_number == '0))
		else $error("absent neighbour carries a number");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(vertex_total) && $stable(vertex_number))
		else $error("waiting result changed before pop");

endmodule

bind grid_to_graph_neighbour_table_core ggnt_checker u_ggnt_checker (.*);
